// ===== rtl/core/tdc_hit_slot_framer_defines.svh =====
// Assertion macros for the hit slot framer.
`ifndef TDC_HIT_SLOT_FRAMER_DEFINES_SVH
`define TDC_HIT_SLOT_FRAMER_DEFINES_SVH
`ifndef SYNTHESIS
`define TSF_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define TSF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TSF_ASSERT_ALWAYS(lbl, expr, msg)
`define TSF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/tdcsf_pkg.sv =====
// Types and constants shared by the hit slot framer.
`timescale 1ns / 1ps
package tdcsf_pkg;

	localparam int unsigned ADDR_W     = 10;
	localparam int unsigned REJ_W      = 10;
	localparam int unsigned HDR_WORDS  = 2;
	localparam int unsigned SLOT_WORDS = 4;
	localparam logic [REJ_W-1:0] REJ_MAX = '1;
	localparam logic [7:0] SLOT_CNT_MAX = 8'hFF;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_HIT   = 2'd1,
		OP_END   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		REG_TIME_OFFSET   = 3'd0,
		REG_BOARD_LATENCY = 3'd1,
		REG_SLOTS_IN_USE  = 3'd2,
		REG_BOARD_NUMBER  = 3'd3,
		REG_TRIGGER_TYPE  = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_LEFTOVER = 3'd0,
		PH_HEADER   = 3'd1,
		PH_BASE     = 3'd2,
		PH_SLOT0    = 3'd3,
		PH_SLOT1    = 3'd4,
		PH_SLOT2    = 3'd5,
		PH_SLOT3    = 3'd6
	} end_phase_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] event_timestamp;
		logic [7:0]  event_fine_time;
		logic [7:0]  straw_address;
		logic        edge_kind;
		logic [31:0] edge_coarse_time;
		logic [4:0]  edge_fine_time;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] word_address;
		logic [31:0]       word_data;
		logic [REJ_W-1:0]  hits_rejected;
		logic              last;
	} out_item_t;

endpackage

// ===== rtl/core/tdc_hit_slot_framer.sv =====
// Hit slot framer: builds one board's event data block from start, hit and end words.
`timescale 1ns / 1ps
// Usage
// Input channel (item_valid/item_ready/item): start, hit and end words of one event.
// Output channel (word_valid/word_ready/word): addressed 32-bit data block words.
// APB port: time_offset @0x00, board_latency @0x04, slots_in_use @0x08,
// board_number @0x0C, trigger_type @0x10; write only while the block is idle.
// An input word is held in the input register; a data word it causes is
// registered in the output register before it is valid at the output.
// Start and hit words go through at one per cycle unless the output stalls. A hit that
// completes a pair of records emits one data word; out-of-window or over-capacity hits
// emit nothing. An end word emits 6 words (7 with an odd leftover record), one per
// cycle from the single output register while the receiver takes them; the input
// register holds the end word until the last slot word goes out; item_ready stays low.
// A stalled receiver holds the output register; the input register then holds
// any word that must emit, and item_ready drops.
// Reset clears all counters and marks the event closed until the next start.
module tdc_hit_slot_framer
	import tdcsf_pkg::*;
#(
	parameter int unsigned MAX_HITS  = 1024,
	parameter int unsigned MAX_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_ready,
	input  in_item_t    item,
	output logic        word_valid,
	input  logic        word_ready,
	output out_item_t   word
);

	`include "tdc_hit_slot_framer_defines.svh"

	localparam int unsigned HC_W = $clog2(MAX_HITS + 1);

	// configuration registers
	logic [31:0] time_offset_q;
	logic [31:0] board_latency_q;
	logic [4:0]  slots_in_use_q;
	logic [5:0]  board_number_q;
	logic [7:0]  trigger_type_q;
	reg_idx_t    reg_idx;

	// event state
	logic [31:0]      window_base_q;
	logic [7:0]       cnt_q [MAX_SLOTS];
	logic [HC_W-1:0]  hit_count_q;
	logic [15:0]      pending_q;
	logic [REJ_W-1:0] rejected_q;
	logic             suppressed_q;
	end_phase_t       end_phase_q;

	// pipeline
	logic      v_s1;
	in_item_t  item_s1;
	logic      word_valid_q;
	out_item_t word_q;

	// datapath
	logic [31:0] slot_diff;
	logic [4:0]  nslots;
	logic        in_window;
	logic        hit_full;
	logic [15:0] rec;
	logic [15:0] hc16;
	logic [15:0] ndata16;
	logic [15:0] blen_bytes;
	logic [ADDR_W-1:0] data_addr;
	logic [7:0]  slot_byte [16];
	logic [2:0]  slot_k_ext;
	logic [1:0]  slot_k;
	logic [31:0] slot_word;
	end_phase_t  eff_phase;
	end_phase_t  next_phase;
	logic        emit_free;
	logic        emit;
	logic        done;
	logic        step;
	logic        hit_take;
	logic        hit_reject;
	logic        end_last;
	out_item_t   emit_word;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_offset_q   <= '0;
			board_latency_q <= '0;
			slots_in_use_q  <= 5'd16;
			board_number_q  <= '0;
			trigger_type_q  <= 8'd1;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_TIME_OFFSET:   time_offset_q   <= pwdata;
				REG_BOARD_LATENCY: board_latency_q <= pwdata;
				REG_SLOTS_IN_USE:  slots_in_use_q  <= pwdata[4:0];
				REG_BOARD_NUMBER:  board_number_q  <= pwdata[5:0];
				REG_TRIGGER_TYPE:  trigger_type_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TIME_OFFSET:   prdata = time_offset_q;
			REG_BOARD_LATENCY: prdata = board_latency_q;
			REG_SLOTS_IN_USE:  prdata = 32'(slots_in_use_q);
			REG_BOARD_NUMBER:  prdata = 32'(board_number_q);
			REG_TRIGGER_TYPE:  prdata = 32'(trigger_type_q);
			default:           prdata = '0;
		endcase
	end

	// ---------------- datapath ----------------
	assign slot_diff = item_s1.edge_coarse_time - window_base_q;
	assign nslots    = (slots_in_use_q < 5'(MAX_SLOTS)) ? slots_in_use_q : 5'(MAX_SLOTS);
	assign in_window = slot_diff < 32'(nslots);
	assign hit_full  = hit_count_q >= HC_W'(MAX_HITS);
	assign rec       = {2'b00, item_s1.straw_address, item_s1.edge_kind,
		item_s1.edge_fine_time};

	assign hc16       = 16'(hit_count_q);
	assign ndata16    = (hc16 + 16'd1) >> 1;
	assign blen_bytes = (ndata16 + 16'(HDR_WORDS + SLOT_WORDS)) << 2;
	assign data_addr  = ADDR_W'(16'(HDR_WORDS) + (hc16 >> 1));

	genvar g;
	generate
		for (g = 0; g < 16; g++) begin : g_slot_byte
			if (g < MAX_SLOTS) begin : g_used
				assign slot_byte[g] = cnt_q[g];
			end else begin : g_unused
				assign slot_byte[g] = 8'h00;
			end
		end
	endgenerate

	// skip the leftover word when the record count is even
	assign eff_phase  = (end_phase_q == PH_LEFTOVER && !hit_count_q[0]) ? PH_HEADER
		: end_phase_q;
	assign next_phase = end_phase_t'(3'(eff_phase) + 3'd1);
	assign slot_k_ext = 3'(eff_phase) - 3'(PH_SLOT0);
	assign slot_k     = slot_k_ext[1:0];
	assign end_last   = (eff_phase == PH_SLOT3);

	always_comb begin
		case (slot_k)
			2'd0:    slot_word = {slot_byte[3], slot_byte[2], slot_byte[1], slot_byte[0]};
			2'd1:    slot_word = {slot_byte[7], slot_byte[6], slot_byte[5], slot_byte[4]};
			2'd2:    slot_word = {slot_byte[11], slot_byte[10], slot_byte[9], slot_byte[8]};
			default: slot_word = {slot_byte[15], slot_byte[14], slot_byte[13], slot_byte[12]};
		endcase
	end

	assign emit_free = !word_valid_q || word_ready;

	always_comb begin
		done       = 1'b1;
		emit       = 1'b0;
		hit_take   = 1'b0;
		hit_reject = 1'b0;
		emit_word  = '0;
		case (op_t'(item_s1.operation))
			OP_HIT: begin
				if (!suppressed_q) begin
					if (!in_window || hit_full) begin
						hit_reject = v_s1;
					end else if (hit_count_q[0]) begin
						// second half closes a data word
						done     = emit_free;
						emit     = v_s1 && emit_free;
						hit_take = v_s1 && emit_free;
						emit_word.word_address = data_addr;
						emit_word.word_data    = {rec, pending_q};
					end else begin
						hit_take = v_s1;
					end
				end
			end
			OP_END: begin
				if (!suppressed_q) begin
					done = emit_free && end_last;
					emit = v_s1 && emit_free;
					case (eff_phase)
						PH_LEFTOVER: begin
							emit_word.word_address = data_addr;
							emit_word.word_data    = {16'h0000, pending_q};
						end
						PH_HEADER: begin
							emit_word.word_address = '0;
							emit_word.word_data    = {blen_bytes, trigger_type_q, 2'b00,
								board_number_q};
						end
						PH_BASE: begin
							emit_word.word_address = ADDR_W'(1);
							emit_word.word_data    = window_base_q;
						end
						default: begin
							emit_word.word_address =
								ADDR_W'(16'(HDR_WORDS) + ndata16 + 16'(slot_k));
							emit_word.word_data     = slot_word;
							emit_word.hits_rejected = end_last ? rejected_q : '0;
							emit_word.last          = end_last;
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	assign step       = v_s1 && done;
	assign item_ready = !v_s1 || step;

	// ---------------- input register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item_ready) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// ---------------- event state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_base_q <= '0;
			hit_count_q   <= '0;
			pending_q     <= '0;
			rejected_q    <= '0;
			suppressed_q  <= 1'b1;
			end_phase_q   <= PH_LEFTOVER;
			for (int j = 0; j < MAX_SLOTS; j++) begin
				cnt_q[j] <= '0;
			end
		end else begin
			if (item_valid && item_ready) begin
				end_phase_q <= PH_LEFTOVER;
			end else if (emit && op_t'(item_s1.operation) == OP_END) begin
				end_phase_q <= next_phase;
			end

			if (step && op_t'(item_s1.operation) == OP_START) begin
				window_base_q <= item_s1.event_timestamp + time_offset_q - board_latency_q;
				hit_count_q   <= '0;
				pending_q     <= '0;
				rejected_q    <= '0;
				suppressed_q  <= (item_s1.event_fine_time == 8'h00);
				for (int j = 0; j < MAX_SLOTS; j++) begin
					cnt_q[j] <= '0;
				end
			end else begin
				if (hit_take) begin
					hit_count_q <= hit_count_q + HC_W'(1);
					pending_q   <= hit_count_q[0] ? 16'h0000 : rec;
					for (int j = 0; j < MAX_SLOTS; j++) begin
						if (slot_diff[3:0] == 4'(j) && cnt_q[j] != SLOT_CNT_MAX) begin
							cnt_q[j] <= cnt_q[j] + 8'd1;
						end
					end
				end
				if (hit_reject && rejected_q != REJ_MAX) begin
					rejected_q <= rejected_q + REJ_W'(1);
				end
				if (step && op_t'(item_s1.operation) == OP_END) begin
					suppressed_q <= 1'b1;
				end
			end
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid_q <= 1'b0;
		end else if (emit) begin
			word_valid_q <= 1'b1;
		end else if (word_ready) begin
			word_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			word_q <= emit_word;
		end
	end

	assign word_valid = word_valid_q;
	assign word       = word_q;

	// ---------------- assertions ----------------
	`TSF_ASSERT_ALWAYS(a_rej_only_last, !(word_valid_q && !word_q.last && word_q.hits_rejected != '0), "reject count on a word that is not last")
	`TSF_ASSERT_ALWAYS(a_hit_bound, hit_count_q <= HC_W'(MAX_HITS), "record count above capacity")
	`TSF_ASSERT_ALWAYS(a_drain_blocks, !(v_s1 && op_t'(item_s1.operation) == OP_END && !suppressed_q && end_phase_q != PH_LEFTOVER && !end_last && item_ready), "input taken during end drain")
	`TSF_ASSERT_NEXT(a_last_closes, emit && emit_word.last, suppressed_q && !v_s1 || suppressed_q, "event not closed after last word")
	`TSF_ASSERT_ALWAYS(a_emit_free, !(emit && word_valid_q && !word_ready), "output word overwritten")

endmodule
